/* rtl/core/pyc_pkg.sv */
// Shared widths, register indexes, constants and types of the PID yaw controller.
`timescale 1ns / 1ps

package pyc_pkg;

    localparam int ANGLE_W = 16;
    localparam int GAIN_W = 16;
    localparam int DUTY_W = 7;
    localparam int PERIOD_W = 24;
    localparam int SUM_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Shared multiplier: signed A operand, unsigned B operand.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int PROD_W = MUL_A_W + MUL_B_W + 1;

    // PID numerator accumulator and the divider built around it.
    localparam int ACC_W = 50;
    localparam int DIVR_W = 24;

    // Pulse width: x / 100 through a reciprocal of 2^RECIP_SHIFT / 100.
    localparam int PROD100_W = 31;
    localparam int RECIP_SHIFT = 31;
    localparam int QUO100_W = 25;
    localparam logic [MUL_B_W-1:0] RECIP100 = 25'd21474836;
    localparam logic [PERIOD_W-1:0] PULSE_LIMIT = 24'hFFFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DIVISOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 3'd6;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [GAIN_W-1:0]   gain_divisor;
        logic [DUTY_W-1:0]   duty_max;
        logic [DUTY_W-1:0]   duty_min;
        logic [PERIOD_W-1:0] pwm_period;
    } cfg_t;

endpackage

/* rtl/core/pid_yaw_controller_pwm_unit.sv */
// Top level of the PID yaw controller with anti-windup and PWM compare output.
//
// Usage: each input transaction carries measured_angle and target_angle and
// yields exactly one output transaction with duty_percent, clamped and
// pulse_width. Both channels use valid/ready; configuration registers are
// written through the cfg channel (cfg_index 0..6), which is always ready,
// and should only be written while no sample is in flight.
// From input acceptance a sample passes through the three PID products on
// the shared multiplier, the bit-serial divider for the PID numerator, the
// clamp, and the pulse width product and its reciprocal division by 100 on
// the shared multiplier before the result is loaded into the output register.
// One sample is in work at a time and the next input is taken in the cycle
// after the result is loaded.
// Reset restores the default gains and limits and clears the previous error
// and the error sum. A finished result waits in the output register while
// the receiver stalls; a new input transaction is taken meanwhile, and its
// result is held back until the output register is free.
`timescale 1ns / 1ps

module pid_yaw_controller_pwm_unit
    import pyc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ANGLE_W-1:0]    measured_angle,
    input  logic [ANGLE_W-1:0]    target_angle,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DUTY_W-1:0]     duty_percent,
    output logic                  clamped,
    output logic [PERIOD_W-1:0]   pulse_width,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL_P = 4'd1;
    localparam logic [3:0] ST_MUL_I = 4'd2;
    localparam logic [3:0] ST_MUL_D = 4'd3;
    localparam logic [3:0] ST_ACC_D = 4'd4;
    localparam logic [3:0] ST_ABS   = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_CLAMP = 4'd7;
    localparam logic [3:0] ST_PMUL  = 4'd8;
    localparam logic [3:0] ST_PREC  = 4'd9;
    localparam logic [3:0] ST_PQ    = 4'd10;
    localparam logic [3:0] ST_PFIX  = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    cfg_t cfg;

    logic [3:0]                 state_reg;
    logic signed [ANGLE_W-1:0]  e_reg;
    logic signed [ANGLE_W:0]    de_reg;
    logic signed [ANGLE_W-1:0]  prev_err_reg;
    logic signed [SUM_W-1:0]    err_sum_reg;
    logic signed [MUL_A_W-1:0]  op_a_reg;
    logic        [MUL_B_W-1:0]  op_b_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       num_neg_reg;
    logic [PROD100_W-1:0]       x_reg;
    logic [QUO100_W-1:0]        q0_reg;
    logic                       fix_reg;
    logic [DUTY_W-1:0]          duty_res_reg;
    logic                       held_res_reg;
    logic                       out_valid_reg;
    logic [DUTY_W-1:0]          duty_reg;
    logic                       held_reg;
    logic [PERIOD_W-1:0]        pulse_reg;

    logic signed [PROD_W-1:0]   prod;
    logic                       div_start;
    logic                       div_done;
    logic [ACC_W-1:0]           quot;

    logic signed [ANGLE_W-1:0]  e_new;
    logic [MUL_B_W-1:0]         gp160;
    logic [MUL_B_W-1:0]         gd160;
    logic signed [MUL_B_W-1:0]  de160;
    logic [GAIN_W-1:0]          divisor_eff;
    logic [DIVR_W-1:0]          div160;
    logic [ACC_W-1:0]           acc_mag;
    logic                       q_neg;
    logic                       q_ge_max;
    logic                       q_le_min;
    logic signed [SUM_W:0]      err_sum_next;
    logic [QUO100_W-1:0]        q0_new;
    logic [PROD100_W:0]         rem100;
    logic [QUO100_W-1:0]        q100;
    logic                       out_free;
    logic                       out_load;

    pyc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pyc_mul u_mul (
        .clk  (clk),
        .op_a (op_a_reg),
        .op_b (op_b_reg),
        .prod (prod)
    );

    pyc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_mag),
        .divisor  (div160),
        .done     (div_done),
        .quotient (quot)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign duty_percent = duty_reg;
    assign clamped = held_reg;
    assign pulse_width = pulse_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == ST_DONE) && out_free;

    assign e_new = $signed(target_angle - measured_angle);

    // Constant scalings by 160 = 128 + 32 are shift-adds.
    assign gp160 = (MUL_B_W'(cfg.gain_p) << 7) + (MUL_B_W'(cfg.gain_p) << 5);
    assign gd160 = (MUL_B_W'(cfg.gain_d) << 7) + (MUL_B_W'(cfg.gain_d) << 5);
    assign de160 = (MUL_B_W'(de_reg) <<< 7) + (MUL_B_W'(de_reg) <<< 5);
    assign divisor_eff = (cfg.gain_divisor == '0) ? GAIN_W'(1) : cfg.gain_divisor;
    assign div160 = (DIVR_W'(divisor_eff) << 7) + (DIVR_W'(divisor_eff) << 5);

    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign div_start = (state_reg == ST_ABS);

    // A negative numerator with a zero magnitude quotient is still zero.
    assign q_neg = num_neg_reg && (quot != '0);
    assign q_ge_max = !q_neg
        && ((quot[ACC_W-1:DUTY_W] != '0) || (quot[DUTY_W-1:0] >= cfg.duty_max));
    assign q_le_min = q_neg
        || ((quot[ACC_W-1:DUTY_W] == '0) && (quot[DUTY_W-1:0] <= cfg.duty_min));

    assign err_sum_next = (SUM_W+1)'(err_sum_reg) + (SUM_W+1)'(e_reg);

    // The reciprocal estimate is low by at most one; the remainder fixes it.
    assign q0_new = prod[RECIP_SHIFT+QUO100_W-1:RECIP_SHIFT];
    assign rem100 = (PROD100_W+1)'(x_reg) - (PROD100_W+1)'(q0_new * 7'd100);
    assign q100 = q0_reg + QUO100_W'(fix_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_err_reg  <= '0;
            err_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        e_reg    <= e_new;
                        de_reg   <= (ANGLE_W+1)'(e_new) - (ANGLE_W+1)'(prev_err_reg);
                        op_a_reg <= MUL_A_W'(e_new);
                        op_b_reg <= gp160;
                        state_reg <= ST_MUL_P;
                    end
                end
                ST_MUL_P:
                begin
                    op_a_reg  <= MUL_A_W'(err_sum_reg);
                    op_b_reg  <= MUL_B_W'(cfg.gain_i);
                    state_reg <= ST_MUL_I;
                end
                ST_MUL_I:
                begin
                    acc_reg   <= prod[ACC_W-1:0];
                    op_a_reg  <= MUL_A_W'(de160);
                    op_b_reg  <= gd160;
                    state_reg <= ST_MUL_D;
                end
                ST_MUL_D:
                begin
                    acc_reg   <= acc_reg + prod[ACC_W-1:0];
                    state_reg <= ST_ACC_D;
                end
                ST_ACC_D:
                begin
                    acc_reg   <= acc_reg + prod[ACC_W-1:0];
                    state_reg <= ST_ABS;
                end
                ST_ABS:
                begin
                    num_neg_reg <= acc_reg[ACC_W-1];
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_CLAMP;
                    end
                end
                ST_CLAMP:
                begin
                    prev_err_reg <= e_reg;
                    op_a_reg     <= MUL_A_W'(cfg.pwm_period);
                    if (q_ge_max)
                    begin
                        duty_res_reg <= cfg.duty_max;
                        held_res_reg <= 1'b1;
                        op_b_reg     <= MUL_B_W'(cfg.duty_max);
                    end
                    else if (q_le_min)
                    begin
                        duty_res_reg <= cfg.duty_min;
                        held_res_reg <= 1'b1;
                        op_b_reg     <= MUL_B_W'(cfg.duty_min);
                    end
                    else
                    begin
                        duty_res_reg <= quot[DUTY_W-1:0];
                        held_res_reg <= 1'b0;
                        op_b_reg     <= MUL_B_W'(quot[DUTY_W-1:0]);
                        if (err_sum_next[SUM_W] != err_sum_next[SUM_W-1])
                        begin
                            err_sum_reg <= err_sum_next[SUM_W]
                                ? {1'b1, {(SUM_W-1){1'b0}}}
                                : {1'b0, {(SUM_W-1){1'b1}}};
                        end
                        else
                        begin
                            err_sum_reg <= err_sum_next[SUM_W-1:0];
                        end
                    end
                    state_reg <= ST_PMUL;
                end
                ST_PMUL:
                begin
                    state_reg <= ST_PREC;
                end
                ST_PREC:
                begin
                    x_reg     <= prod[PROD100_W-1:0];
                    op_a_reg  <= MUL_A_W'(prod[PROD100_W-1:0]);
                    op_b_reg  <= RECIP100;
                    state_reg <= ST_PQ;
                end
                ST_PQ:
                begin
                    state_reg <= ST_PFIX;
                end
                ST_PFIX:
                begin
                    q0_reg    <= q0_new;
                    fix_reg   <= (rem100 >= (PROD100_W+1)'(100));
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // The output register is loaded only once the previous result has left.
                    if (out_free)
                    begin
                        duty_reg  <= duty_res_reg;
                        held_reg  <= held_res_reg;
                        pulse_reg <= q100[QUO100_W-1] ? PULSE_LIMIT
                                                      : q100[PERIOD_W-1:0];
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/pyc_cfg.sv */
// Configuration register file of the PID yaw controller.
`timescale 1ns / 1ps

module pyc_cfg
    import pyc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p       <= 16'd1200;
            cfg_reg.gain_i       <= 16'd100;
            cfg_reg.gain_d       <= 16'd400;
            cfg_reg.gain_divisor <= 16'd1000;
            cfg_reg.duty_max     <= 7'd98;
            cfg_reg.duty_min     <= 7'd2;
            cfg_reg.pwm_period   <= 24'd16000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GAIN_P:       cfg_reg.gain_p       <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:       cfg_reg.gain_i       <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:       cfg_reg.gain_d       <= cfg_data[GAIN_W-1:0];
                REG_GAIN_DIVISOR: cfg_reg.gain_divisor <= cfg_data[GAIN_W-1:0];
                REG_DUTY_MAX:     cfg_reg.duty_max     <= cfg_data[DUTY_W-1:0];
                REG_DUTY_MIN:     cfg_reg.duty_min     <= cfg_data[DUTY_W-1:0];
                REG_PWM_PERIOD:   cfg_reg.pwm_period   <= cfg_data[PERIOD_W-1:0];
                default:          ;
            endcase
        end
    end

endmodule

/* rtl/core/pyc_mul.sv */
// Shared signed-by-unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module pyc_mul
    import pyc_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic        [MUL_B_W-1:0] op_b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a * $signed({1'b0, op_b}));
    end

endmodule

/* rtl/core/pyc_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module pyc_div
    import pyc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ACC_W-1:0]  dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic              done,
    output logic [ACC_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]  quot_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] divisor_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVR_W:0]   shifted;
    logic [DIVR_W+1:0] diff;

    assign shifted = {rem_reg, quot_reg[ACC_W-1]};
    assign diff = {1'b0, shifted} - {2'b00, divisor_reg};
    assign done = done_reg;
    assign quotient = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == CNT_W'(ACC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // A nonnegative trial difference means the divisor fits here.
            if (!diff[DIVR_W+1])
            begin
                rem_reg  <= diff[DIVR_W-1:0];
                quot_reg <= {quot_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[DIVR_W-1:0];
                quot_reg <= {quot_reg[ACC_W-2:0], 1'b0};
            end
        end
    end

endmodule

/* dv/pid_yaw_controller_pwm_unit_checker.sv */
// Checker for the PID yaw controller: tracks registers, predicts each drive result, compares.
`timescale 1ns / 1ps

module pid_yaw_controller_pwm_unit_checker
    import pyc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [ANGLE_W-1:0]    measured_angle,
    input  logic [ANGLE_W-1:0]    target_angle,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [DUTY_W-1:0]     duty_percent,
    input  logic                  clamped,
    input  logic [PERIOD_W-1:0]   pulse_width,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding,
    output int                    result_count,
    output int                    held_count
);

    typedef struct packed {
        logic [DUTY_W-1:0]   duty;
        logic                held;
        logic [PERIOD_W-1:0] pulse;
    } drive_t;

    localparam longint SUM_HI = 64'sh7FFFFFFF;
    localparam longint SUM_LO = -64'sh80000000;

    cfg_t                      regs;
    logic signed [ANGLE_W-1:0] last_error;
    longint                    integral;
    drive_t                    pending_drive_q[$];
    int                        errs;
    int                        n_results;
    int                        n_held;

    // Works out one drive result and advances the controller state.
    function automatic drive_t predict_drive(input logic [ANGLE_W-1:0] meas,
                                             input logic [ANGLE_W-1:0] tgt);
        logic signed [ANGLE_W-1:0] err;
        longint e;
        longint de;
        longint kp;
        longint ki;
        longint kd;
        longint den;
        longint per;
        longint num;
        longint q;
        longint lim_hi;
        longint lim_lo;
        longint duty;
        longint pulse;
        drive_t r;
        err = tgt - meas;
        e = err;
        de = e - longint'(last_error);
        kp = regs.gain_p;
        ki = regs.gain_i;
        kd = regs.gain_d;
        den = regs.gain_divisor;
        if (den == 0)
        begin
            den = 1;
        end
        den = den * 160;
        num = 160 * kp * e + ki * integral + 25600 * kd * de;
        q = num / den;
        lim_hi = regs.duty_max;
        lim_lo = regs.duty_min;
        if (q >= lim_hi)
        begin
            duty = lim_hi;
            r.held = 1'b1;
        end
        else if (q <= lim_lo)
        begin
            duty = lim_lo;
            r.held = 1'b1;
        end
        else
        begin
            duty = q;
            r.held = 1'b0;
            integral = integral + e;
            if (integral > SUM_HI)
            begin
                integral = SUM_HI;
            end
            if (integral < SUM_LO)
            begin
                integral = SUM_LO;
            end
        end
        last_error = err;
        per = regs.pwm_period;
        pulse = per * duty / 100;
        r.duty = duty[DUTY_W-1:0];
        r.pulse = (pulse > 64'sh00FFFFFF) ? PULSE_LIMIT : pulse[PERIOD_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_t want;
        if (!rst_n)
        begin
            regs.gain_p = 16'd1200;
            regs.gain_i = 16'd100;
            regs.gain_d = 16'd400;
            regs.gain_divisor = 16'd1000;
            regs.duty_max = 7'd98;
            regs.duty_min = 7'd2;
            regs.pwm_period = 24'd16000;
            last_error = '0;
            integral = 0;
            pending_drive_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_P:       regs.gain_p = cfg_data[GAIN_W-1:0];
                    REG_GAIN_I:       regs.gain_i = cfg_data[GAIN_W-1:0];
                    REG_GAIN_D:       regs.gain_d = cfg_data[GAIN_W-1:0];
                    REG_GAIN_DIVISOR: regs.gain_divisor = cfg_data[GAIN_W-1:0];
                    REG_DUTY_MAX:     regs.duty_max = cfg_data[DUTY_W-1:0];
                    REG_DUTY_MIN:     regs.duty_min = cfg_data[DUTY_W-1:0];
                    REG_PWM_PERIOD:   regs.pwm_period = cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (pending_drive_q.size() == 0)
                begin
                    $error("result with no sample waiting: duty_percent %0d, clamped %0d, pulse_width %0d",
                           duty_percent, clamped, pulse_width);
                    errs++;
                end
                else
                begin
                    want = pending_drive_q.pop_front();
                    if (duty_percent !== want.duty)
                    begin
                        $error("duty_percent mismatch: expected %0d, actual %0d",
                               want.duty, duty_percent);
                        errs++;
                    end
                    if (clamped !== want.held)
                    begin
                        $error("clamped mismatch: expected %0d, actual %0d", want.held, clamped);
                        errs++;
                    end
                    if (pulse_width !== want.pulse)
                    begin
                        $error("pulse_width mismatch: expected %0d, actual %0d",
                               want.pulse, pulse_width);
                        errs++;
                    end
                    n_results++;
                    if (want.held)
                    begin
                        n_held++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pending_drive_q.push_back(predict_drive(measured_angle, target_angle));
            end
        end
        fail_count <= errs;
        outstanding <= pending_drive_q.size();
        result_count <= n_results;
        held_count <= n_held;
    end

endmodule

/* dv/pid_yaw_controller_pwm_unit_test.sv */
// Testbench top for the PID yaw controller: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module pid_yaw_controller_pwm_unit_test;
    import pyc_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int RAND_PHASES = 14;
    localparam int ITEMS_PER_PHASE = 95;
    localparam int DIRECTED_SETTINGS = 6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum int {CFG_TAME, CFG_WILD, CFG_TOP, CFG_BOTTOM} cfg_kind_t;
    typedef enum logic [1:0] {SINK_FREE, SINK_COIN, SINK_SPARSE, SINK_HOLD} sink_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [ANGLE_W-1:0]    measured_angle = '0;
    logic [ANGLE_W-1:0]    target_angle = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [DUTY_W-1:0]     duty_percent;
    logic                  clamped;
    logic [PERIOD_W-1:0]   pulse_width;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int outstanding;
    int result_count;
    int held_count;
    int sent_count = 0;
    int burst_left = 4;
    int cycle_count = 0;
    int mode_span = 0;
    sink_mode_t sink_mode = SINK_FREE;

    pid_yaw_controller_pwm_unit dut (.*);

    pid_yaw_controller_pwm_unit_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // The receiver switches between free running, coin flips, sparse accepts and long holds.
    always @(posedge clk)
    begin
        if (mode_span == 0)
        begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
            mode_span <= $urandom_range(8, 200);
        end
        else
        begin
            mode_span <= mode_span - 1;
        end
        case (sink_mode)
            SINK_FREE:   out_ready <= 1'b1;
            SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
            SINK_SPARSE: out_ready <= ($urandom_range(0, 5) == 0);
            default:     out_ready <= 1'b0;
        endcase
    end

    // Register writes carry random junk in any data bits above the register's width.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val, input int w);
        int unsigned junk;
        junk = $urandom;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'((junk << w) | val);
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apply_config(input cfg_t c);
        cfg_write(REG_GAIN_P, c.gain_p, GAIN_W);
        cfg_write(REG_GAIN_I, c.gain_i, GAIN_W);
        cfg_write(REG_GAIN_D, c.gain_d, GAIN_W);
        cfg_write(REG_GAIN_DIVISOR, c.gain_divisor, GAIN_W);
        cfg_write(REG_DUTY_MAX, c.duty_max, DUTY_W);
        cfg_write(REG_DUTY_MIN, c.duty_min, DUTY_W);
        cfg_write(REG_PWM_PERIOD, c.pwm_period, PERIOD_W);
        cfg_write(REG_UNUSED, $urandom, 0);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Valid stays high across a burst; a gap with valid low ends each burst.
    task automatic send_sample(input logic [ANGLE_W-1:0] m, input logic [ANGLE_W-1:0] t);
        int gap;
        in_valid <= 1'b1;
        measured_angle <= m;
        target_angle <= t;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sent_count++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 90) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
    endtask

    // Holds the sender off until every sample in flight has produced its result.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, outstanding);
        $display("** pid_yaw_controller_pwm_unit: FAILED **");
        $finish;
    end

    initial
    begin
        cfg_t c;
        cfg_kind_t kind;
        logic [ANGLE_W-1:0] m;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes under the reset settings.
        send_sample(16'd0, 16'd0);
        send_sample(16'd0, 16'hFFFF);
        send_sample(16'd0, 16'h7FFF);
        send_sample(16'd0, 16'h8000);
        send_sample(16'hFFFF, 16'd0);
        send_sample(16'hFFFF, 16'hFFFF);
        wait_idle();

        // Unit proportional gain over a unit divisor makes the raw duty equal the error,
        // so samples can land exactly on each limit and just past it.
        c = '{gain_p: 16'd1, gain_i: 16'd0, gain_d: 16'd0, gain_divisor: 16'd1,
              duty_max: 7'd60, duty_min: 7'd10, pwm_period: 24'd1000};
        apply_config(c);
        send_sample(16'd0, 16'd60);
        send_sample(16'd0, 16'd61);
        send_sample(16'd0, 16'd10);
        send_sample(16'd0, 16'd9);
        send_sample(16'd0, 16'd35);
        send_sample(16'd0, 16'hFFFB);
        wait_idle();

        // Zero divisor behaves as one; the lower limit sits above the upper one.
        c.gain_divisor = 16'd0;
        c.duty_max = 7'd20;
        c.duty_min = 7'd80;
        apply_config(c);
        send_sample(16'd0, 16'd50);
        send_sample(16'd0, 16'd10);
        send_sample(16'd0, 16'd90);
        wait_idle();

        // Every gain at full scale with the largest error step.
        c = '{gain_p: 16'hFFFF, gain_i: 16'hFFFF, gain_d: 16'hFFFF, gain_divisor: 16'hFFFF,
              duty_max: 7'd100, duty_min: 7'd0, pwm_period: 24'hFFFFFF};
        apply_config(c);
        send_sample(16'd0, 16'h7FFF);
        send_sample(16'd0, 16'h8000);
        wait_idle();

        // A limit above 100 percent with the longest period overflows the pulse width.
        c = '{gain_p: 16'd1, gain_i: 16'd0, gain_d: 16'd0, gain_divisor: 16'd1,
              duty_max: 7'd127, duty_min: 7'd127, pwm_period: 24'hFFFFFF};
        apply_config(c);
        send_sample(16'd0, 16'd200);
        wait_idle();
        c.pwm_period = 24'd0;
        apply_config(c);
        send_sample(16'd0, 16'd200);

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_idle();
            if (ph == 2)
            begin
                kind = CFG_TOP;
            end
            else if (ph == 6)
            begin
                kind = CFG_BOTTOM;
            end
            else
            begin
                kind = ($urandom_range(0, 3) == 0) ? CFG_WILD : CFG_TAME;
            end
            case (kind)
                CFG_TAME:
                begin
                    // Gains scaled to the divisor keep many samples inside the limits,
                    // which lets the error sum actually integrate.
                    c.gain_divisor = 16'($urandom_range(1, 4000));
                    c.gain_p = 16'($urandom_range(0, 2 * c.gain_divisor));
                    c.gain_i = 16'($urandom_range(0, c.gain_divisor));
                    c.gain_d = 16'($urandom_range(0, c.gain_divisor / 100));
                    c.duty_min = 7'($urandom_range(0, 30));
                    c.duty_max = 7'($urandom_range(50, 100));
                    if ($urandom_range(0, 7) == 0)
                    begin
                        c.duty_min = 7'($urandom_range(60, 127));
                    end
                    c.pwm_period = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(1, 20000))
                                                               : 24'($urandom);
                end
                CFG_WILD:
                begin
                    c.gain_p = 16'($urandom);
                    c.gain_i = 16'($urandom);
                    c.gain_d = 16'($urandom);
                    c.gain_divisor = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
                    c.duty_max = 7'($urandom);
                    c.duty_min = 7'($urandom);
                    c.pwm_period = 24'($urandom);
                end
                CFG_TOP:    c = '1;
                default:    c = '0;
            endcase
            apply_config(c);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                m = 16'($urandom);
                if ((kind == CFG_TAME) ? ($urandom_range(0, 6) != 0)
                                       : ($urandom_range(0, 1) == 0))
                begin
                    send_sample(m, 16'(m + $urandom_range(0, 160) - 80));
                end
                else
                begin
                    send_sample(m, 16'($urandom));
                end
            end
        end

        wait_idle();
        repeat (70) @(posedge clk);
        $display("Drove %0d samples through %0d register settings; %0d results checked, %0d clamped.",
                 sent_count, RAND_PHASES + DIRECTED_SETTINGS, result_count, held_count);
        if (fail_count == 0)
        begin
            $display("** pid_yaw_controller_pwm_unit: PASSED **");
        end
        else
        begin
            $display("** pid_yaw_controller_pwm_unit: FAILED **");
        end
        $finish;
    end

endmodule
